[hdl/xfec_pkg.sv]
package xfec_pkg;

   localparam int SEQ_W  = 32;
   localparam int WORD_W = 64;
   localparam int POS_W  = 5;
   localparam int KIND_W = 2;
   localparam int GS_W   = 4;
   localparam int FIG_W  = 3;

   localparam logic       MODE_DATA = 1'b0;
   localparam logic       MODE_NACK = 1'b1;

   localparam logic [KIND_W-1:0] KIND_DATA   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PARITY = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RETX   = 2'd2;

   localparam logic [GS_W-1:0] GROUP_SIZE_RESET = 4'd2;
   localparam logic [GS_W-1:0] GROUP_SIZE_MIN   = 4'd1;
   localparam logic [GS_W-1:0] GROUP_SIZE_MAX   = 4'd8;

   localparam int CMD_DEPTH = 4;
   localparam int RSP_DEPTH = 4;
   localparam int RSP_CNT_W = 3;

   typedef struct packed {
      logic              mode;
      logic [SEQ_W-1:0]  seq_number;
      logic [WORD_W-1:0] payload_word;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0] packet_kind;
      logic [SEQ_W-1:0]  packet_seq;
      logic [WORD_W-1:0] word_out;
      logic [POS_W-1:0]  word_position;
      logic              end_of_packet;
      logic              end_of_run;
   } rsp_type;

   typedef struct packed {
      logic              is_nack;
      logic              hit_valid;
      logic [SEQ_W-1:0]  seq;
      logic [WORD_W-1:0] word;
      logic [POS_W-1:0]  pos;
      logic              eop;
      logic              parity_follow;
      logic [SEQ_W-1:0]  parity_seq;
   } cmd_type;

endpackage

[hdl/xfec_ram.sv]
module xfec_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/xfec_fifo.sv]
module xfec_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty,
   output logic [CNT_W-1:0] count
);

   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = entry_ff[rd_ptr_ff];
   assign count   = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

[hdl/xfec_front.sv]
module xfec_front #(
   parameter int HISTORY_SLOTS = 256,
   parameter int WORDS_PER_FRAME = 20,
   localparam int SLOT_W = (HISTORY_SLOTS > 1) ? $clog2(HISTORY_SLOTS) : 1,
   localparam int HADDR_W = (HISTORY_SLOTS * WORDS_PER_FRAME > 1) ?
                            $clog2(HISTORY_SLOTS * WORDS_PER_FRAME) : 1,
   localparam int IDX_W = (WORDS_PER_FRAME > 1) ? $clog2(WORDS_PER_FRAME) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  xfec_pkg::req_type     req_payload,
   input  logic                  csr_write_enable,
   input  logic [3:0]            csr_write_data,
   input  logic                  cmd_full,
   output logic                  cmd_push,
   output xfec_pkg::cmd_type     cmd_data,
   output logic [SLOT_W-1:0]     cmd_slot,
   input  logic                  burst_done,
   input  logic [IDX_W-1:0]      parity_rd_idx,
   output logic [63:0]           parity_rd_word,
   output logic                  hist_wr_en,
   output logic [HADDR_W-1:0]    hist_wr_addr,
   output logic [63:0]           hist_wr_data,
   output logic                  tag_wr_en,
   output logic [SLOT_W-1:0]     tag_wr_addr,
   output logic [31:0]           tag_wr_data
);
   import xfec_pkg::*;

   localparam logic [SEQ_W-1:0]  RECIP    = SEQ_W'(64'hFFFF_FFFF / HISTORY_SLOTS);
   localparam logic [SLOT_W:0]   SLOTS_N  = (SLOT_W + 1)'(HISTORY_SLOTS);
   localparam logic [POS_W-1:0]  LAST_POS = POS_W'(WORDS_PER_FRAME - 1);

   // slot reduction pipeline
   logic                  s1_valid_ff;
   req_type               s1_item_ff;
   logic [SEQ_W-1:0]      s1_quot_ff;
   logic                  s2_valid_ff;
   req_type               s2_item_ff;
   logic [SLOT_W:0]       s2_rem_ff;
   logic                  s3_valid_ff;
   req_type               s3_item_ff;
   logic [SLOT_W-1:0]     s3_slot_ff;

   logic [2*SEQ_W-1:0]    product;
   logic [SEQ_W-1:0]      diff;
   logic [SLOT_W-1:0]     slot_in;
   logic                  advance;
   logic                  commit;

   // frame and group state
   logic [GS_W-1:0]          group_size_ff;
   logic [POS_W-1:0]         word_counter_ff;
   logic [POS_W-1:0]         word_counter_in;
   logic [FIG_W-1:0]         fig_ff;
   logic [FIG_W-1:0]         fig_in;
   logic [SEQ_W-1:0]         gfs_ff;
   logic [SEQ_W-1:0]         gfs_in;
   logic [HISTORY_SLOTS-1:0] valid_ff;
   logic [HISTORY_SLOTS-1:0] valid_in;
   logic                     block_ff;
   logic                     block_in;
   logic [WORD_W-1:0]        acc_ff [WORDS_PER_FRAME];

   logic                  is_data;
   logic [POS_W-1:0]      wc;
   logic                  last;
   logic [GS_W-1:0]       gs_eff;
   logic                  group_end;
   logic                  first_of_group;

   assign product = {{SEQ_W{1'b0}}, req_payload.seq_number} * {{SEQ_W{1'b0}}, RECIP};
   assign diff    = s1_item_ff.seq_number - SEQ_W'(s1_quot_ff * SEQ_W'(HISTORY_SLOTS));
   assign slot_in = (s2_rem_ff >= SLOTS_N) ? SLOT_W'(s2_rem_ff - SLOTS_N)
                                          : s2_rem_ff[SLOT_W-1:0];

   assign commit   = s3_valid_ff && !cmd_full && !block_ff;
   assign advance  = !s3_valid_ff || commit;
   assign req_full = !advance;

   assign is_data = (s3_item_ff.mode == MODE_DATA);
   assign wc      = (word_counter_ff > LAST_POS) ? '0 : word_counter_ff;
   assign last    = (wc == LAST_POS);

   always_comb begin
      if (group_size_ff == '0) begin
         gs_eff = GROUP_SIZE_MIN;
      end else if (group_size_ff > GROUP_SIZE_MAX) begin
         gs_eff = GROUP_SIZE_MAX;
      end else begin
         gs_eff = group_size_ff;
      end
   end

   assign group_end      = last && (({1'b0, fig_ff} + 4'd1) >= gs_eff);
   assign first_of_group = (wc == '0) && (fig_ff == '0);

   always_comb begin
      valid_in        = valid_ff;
      word_counter_in = word_counter_ff;
      fig_in          = fig_ff;
      gfs_in          = gfs_ff;
      block_in        = block_ff;
      if (burst_done) begin
         block_in = 1'b0;
      end
      if (commit) begin
         if (is_data) begin
            if (wc == '0) begin
               valid_in[s3_slot_ff] = 1'b0;
            end
            if (first_of_group) begin
               gfs_in = s3_item_ff.seq_number;
            end
            if (last) begin
               valid_in[s3_slot_ff] = 1'b1;
               word_counter_in      = '0;
               fig_in               = group_end ? '0 : fig_ff + 1'b1;
            end else begin
               word_counter_in = wc + 1'b1;
            end
         end
         if (!is_data || group_end) begin
            block_in = 1'b1;
         end
      end
   end

   assign cmd_push               = commit;
   assign cmd_slot               = s3_slot_ff;
   assign cmd_data.is_nack       = (s3_item_ff.mode == MODE_NACK);
   assign cmd_data.hit_valid     = valid_ff[s3_slot_ff];
   assign cmd_data.seq           = s3_item_ff.seq_number;
   assign cmd_data.word          = s3_item_ff.payload_word;
   assign cmd_data.pos           = wc;
   assign cmd_data.eop           = last;
   assign cmd_data.parity_follow = is_data && group_end;
   assign cmd_data.parity_seq    = first_of_group ? s3_item_ff.seq_number : gfs_ff;

   assign hist_wr_en   = commit && is_data;
   assign hist_wr_addr = HADDR_W'(s3_slot_ff) * HADDR_W'(WORDS_PER_FRAME) + HADDR_W'(wc);
   assign hist_wr_data = s3_item_ff.payload_word;
   assign tag_wr_en    = commit && is_data && last;
   assign tag_wr_addr  = s3_slot_ff;
   assign tag_wr_data  = s3_item_ff.seq_number;

   assign parity_rd_word = acc_ff[parity_rd_idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         s2_valid_ff     <= 1'b0;
         s3_valid_ff     <= 1'b0;
         group_size_ff   <= GROUP_SIZE_RESET;
         word_counter_ff <= '0;
         fig_ff          <= '0;
         gfs_ff          <= '0;
         valid_ff        <= '0;
         block_ff        <= 1'b0;
      end else begin
         if (advance) begin
            s1_valid_ff <= req_push;
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
         end
         if (csr_write_enable) begin
            group_size_ff <= csr_write_data;
         end
         word_counter_ff <= word_counter_in;
         fig_ff          <= fig_in;
         gfs_ff          <= gfs_in;
         valid_ff        <= valid_in;
         block_ff        <= block_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_item_ff <= req_payload;
         s1_quot_ff <= product[2*SEQ_W-1:SEQ_W];
         s2_item_ff <= s1_item_ff;
         s2_rem_ff  <= diff[SLOT_W:0];
         s3_item_ff <= s2_item_ff;
         s3_slot_ff <= slot_in;
      end
      if (commit && is_data) begin
         acc_ff[wc[IDX_W-1:0]] <= (fig_ff == '0) ? s3_item_ff.payload_word
                                 : acc_ff[wc[IDX_W-1:0]] ^ s3_item_ff.payload_word;
      end
   end

   a_done_while_blocked: assert property (@(posedge clock) disable iff (reset)
      burst_done |-> block_ff)
      else $error("burst completion seen with no burst outstanding");

   a_slot_valid_after_frame: assert property (@(posedge clock) disable iff (reset)
      (commit && is_data && last) |=> valid_ff[$past(s3_slot_ff)])
      else $error("history slot not marked valid after its frame closed");

   a_word_counter_range: assert property (@(posedge clock) disable iff (reset)
      word_counter_ff <= LAST_POS)
      else $error("word counter beyond frame length");

endmodule

[hdl/xfec_back.sv]
module xfec_back #(
   parameter int HISTORY_SLOTS = 256,
   parameter int WORDS_PER_FRAME = 20,
   localparam int SLOT_W = (HISTORY_SLOTS > 1) ? $clog2(HISTORY_SLOTS) : 1,
   localparam int HADDR_W = (HISTORY_SLOTS * WORDS_PER_FRAME > 1) ?
                            $clog2(HISTORY_SLOTS * WORDS_PER_FRAME) : 1,
   localparam int IDX_W = (WORDS_PER_FRAME > 1) ? $clog2(WORDS_PER_FRAME) : 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            cmd_empty,
   output logic                            cmd_pop,
   input  xfec_pkg::cmd_type               cmd_data,
   input  logic [SLOT_W-1:0]               cmd_slot,
   output logic                            burst_done,
   output logic [IDX_W-1:0]                parity_rd_idx,
   input  logic [63:0]                     parity_rd_word,
   output logic                            tag_rd_en,
   output logic [SLOT_W-1:0]               tag_rd_addr,
   input  logic [31:0]                     tag_rd_data,
   output logic                            hist_rd_en,
   output logic [HADDR_W-1:0]              hist_rd_addr,
   input  logic [63:0]                     hist_rd_data,
   input  logic [xfec_pkg::RSP_CNT_W-1:0]  out_count,
   output logic                            out_push,
   output xfec_pkg::rsp_type               out_data
);
   import xfec_pkg::*;

   localparam logic [POS_W-1:0] LAST_POS = POS_W'(WORDS_PER_FRAME - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TAG_WAIT,
      ST_PARITY,
      ST_RETX
   } state_type;

   state_type           state_ff;
   logic [POS_W-1:0]    cnt_ff;
   logic [SEQ_W-1:0]    seq_ff;
   logic [SLOT_W-1:0]   slot_ff;
   logic                hit_valid_ff;
   logic                s1_valid_ff;
   rsp_type             s1_meta_ff;
   logic                s1_from_ram_ff;

   logic [RSP_CNT_W-1:0] occupancy;
   logic                 can_issue;
   logic                 burst_last;
   logic                 issue_parity;
   logic                 issue_retx;
   logic                 tag_hit;

   assign occupancy    = out_count + RSP_CNT_W'(s1_valid_ff);
   assign can_issue    = occupancy < RSP_CNT_W'(RSP_DEPTH);
   assign burst_last   = (cnt_ff == LAST_POS);
   assign issue_parity = (state_ff == ST_PARITY) && can_issue;
   assign issue_retx   = (state_ff == ST_RETX) && can_issue;
   assign tag_hit      = hit_valid_ff && (tag_rd_data == seq_ff);

   assign cmd_pop      = (state_ff == ST_IDLE) && !cmd_empty && can_issue;
   assign tag_rd_en    = cmd_pop && cmd_data.is_nack;
   assign tag_rd_addr  = cmd_slot;
   assign hist_rd_en   = issue_retx;
   assign hist_rd_addr = HADDR_W'(slot_ff) * HADDR_W'(WORDS_PER_FRAME) + HADDR_W'(cnt_ff);
   assign parity_rd_idx = cnt_ff[IDX_W-1:0];

   assign burst_done = ((issue_parity || issue_retx) && burst_last) ||
                       ((state_ff == ST_TAG_WAIT) && !tag_hit);

   always_comb begin
      out_data = s1_meta_ff;
      if (s1_from_ram_ff) begin
         out_data.word_out = hist_rd_data;
      end
   end
   assign out_push = s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd_pop) begin
                  if (cmd_data.is_nack) begin
                     seq_ff       <= cmd_data.seq;
                     slot_ff      <= cmd_slot;
                     hit_valid_ff <= cmd_data.hit_valid;
                     state_ff     <= ST_TAG_WAIT;
                  end else begin
                     s1_valid_ff                <= 1'b1;
                     s1_from_ram_ff             <= 1'b0;
                     s1_meta_ff.packet_kind     <= KIND_DATA;
                     s1_meta_ff.packet_seq      <= cmd_data.seq;
                     s1_meta_ff.word_out        <= cmd_data.word;
                     s1_meta_ff.word_position   <= cmd_data.pos;
                     s1_meta_ff.end_of_packet   <= cmd_data.eop;
                     s1_meta_ff.end_of_run      <= !cmd_data.parity_follow;
                     if (cmd_data.parity_follow) begin
                        seq_ff   <= cmd_data.parity_seq;
                        cnt_ff   <= '0;
                        state_ff <= ST_PARITY;
                     end
                  end
               end
            end
            ST_TAG_WAIT: begin
               if (tag_hit) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_RETX;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_PARITY, ST_RETX: begin
               if (can_issue) begin
                  s1_valid_ff                <= 1'b1;
                  s1_from_ram_ff             <= (state_ff == ST_RETX);
                  s1_meta_ff.packet_kind     <= (state_ff == ST_RETX) ? KIND_RETX : KIND_PARITY;
                  s1_meta_ff.packet_seq      <= seq_ff;
                  s1_meta_ff.word_out        <= parity_rd_word;
                  s1_meta_ff.word_position   <= cnt_ff;
                  s1_meta_ff.end_of_packet   <= burst_last;
                  s1_meta_ff.end_of_run      <= burst_last;
                  if (burst_last) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     cnt_ff <= cnt_ff + 1'b1;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (out_count < RSP_CNT_W'(RSP_DEPTH)))
      else $error("result queue overrun");

   a_tag_wait_single: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TAG_WAIT) |=> (state_ff == ST_RETX || state_ff == ST_IDLE))
      else $error("tag lookup did not resolve in one cycle");

endmodule

[hdl/xor_fec_sender_with_retransmit_core.sv]
// XOR parity FEC sender with NACK retransmission. Data words (mode 0) are forwarded one
// result each, stored in a history ring at slot seq mod HISTORY_SLOTS and folded into a
// parity accumulator; the word closing a frame that completes a group of group_size frames
// also yields a parity packet of WORDS_PER_FRAME words. A NACK (mode 1) that hits a valid
// slot with a matching tag replays the stored frame, otherwise it yields nothing. An item
// passes a three-stage slot reduction pipeline (reciprocal multiply, multiply-subtract,
// correction) before it updates state and goes through the command queue and the back
// end's output register to the result queue; a new item can enter behind it unless the
// pipeline stalls. A word that ends a parity group, or a NACK, stalls the pipeline behind
// it until the back end has read out its burst: the back end takes the command, then
// issues the WORDS_PER_FRAME parity words, or looks up the tag of a NACK and replays the
// frame (a NACK that misses releases after the lookup), one result per cycle while the
// consumer pops. Slot valid bits clear at reset; no clearing pass runs.
module xor_fec_sender_with_retransmit_core #(
   parameter int HISTORY_SLOTS = 256,
   parameter int WORDS_PER_FRAME = 20
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  xfec_pkg::req_type req_payload,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output xfec_pkg::rsp_type rsp_payload,
   input  logic              csr_write_enable,
   input  logic [3:0]        csr_write_data
);
   import xfec_pkg::*;

   localparam int SLOT_W  = (HISTORY_SLOTS > 1) ? $clog2(HISTORY_SLOTS) : 1;
   localparam int HDEPTH  = HISTORY_SLOTS * WORDS_PER_FRAME;
   localparam int HADDR_W = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;
   localparam int IDX_W   = (WORDS_PER_FRAME > 1) ? $clog2(WORDS_PER_FRAME) : 1;
   localparam int CMDQ_W  = SLOT_W + $bits(cmd_type);
   localparam int RSP_W   = $bits(rsp_type);

   logic                  cmd_push;
   cmd_type               cmd_wr;
   logic [SLOT_W-1:0]     cmd_wr_slot;
   logic                  cmd_full;
   logic                  cmd_pop;
   logic                  cmd_empty;
   logic [CMDQ_W-1:0]     cmd_rd;
   cmd_type               cmd_rd_data;
   logic [SLOT_W-1:0]     cmd_rd_slot;

   logic                  burst_done;
   logic [IDX_W-1:0]      parity_rd_idx;
   logic [WORD_W-1:0]     parity_rd_word;

   logic                  hist_wr_en;
   logic [HADDR_W-1:0]    hist_wr_addr;
   logic [WORD_W-1:0]     hist_wr_data;
   logic                  hist_rd_en;
   logic [HADDR_W-1:0]    hist_rd_addr;
   logic [WORD_W-1:0]     hist_rd_data;

   logic                  tag_wr_en;
   logic [SLOT_W-1:0]     tag_wr_addr;
   logic [SEQ_W-1:0]      tag_wr_data;
   logic                  tag_rd_en;
   logic [SLOT_W-1:0]     tag_rd_addr;
   logic [SEQ_W-1:0]      tag_rd_data;

   logic                  out_push;
   rsp_type               out_data;
   logic [RSP_CNT_W-1:0]  out_count;
   logic [RSP_W-1:0]      out_rd;

   assign {cmd_rd_slot, cmd_rd_data} = cmd_rd;
   assign rsp_payload = out_rd;

   xfec_front #(
      .HISTORY_SLOTS   (HISTORY_SLOTS),
      .WORDS_PER_FRAME (WORDS_PER_FRAME)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd_full         (cmd_full),
      .cmd_push         (cmd_push),
      .cmd_data         (cmd_wr),
      .cmd_slot         (cmd_wr_slot),
      .burst_done       (burst_done),
      .parity_rd_idx    (parity_rd_idx),
      .parity_rd_word   (parity_rd_word),
      .hist_wr_en       (hist_wr_en),
      .hist_wr_addr     (hist_wr_addr),
      .hist_wr_data     (hist_wr_data),
      .tag_wr_en        (tag_wr_en),
      .tag_wr_addr      (tag_wr_addr),
      .tag_wr_data      (tag_wr_data)
   );

   xfec_fifo #(
      .WIDTH (CMDQ_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .wr_data ({cmd_wr_slot, cmd_wr}),
      .full    (cmd_full),
      .pop     (cmd_pop),
      .rd_data (cmd_rd),
      .empty   (cmd_empty),
      .count   ()
   );

   xfec_ram #(
      .WIDTH (WORD_W),
      .DEPTH (HDEPTH)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_wr_en),
      .wr_addr (hist_wr_addr),
      .wr_data (hist_wr_data),
      .rd_en   (hist_rd_en),
      .rd_addr (hist_rd_addr),
      .rd_data (hist_rd_data)
   );

   xfec_ram #(
      .WIDTH (SEQ_W),
      .DEPTH (HISTORY_SLOTS)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_wr_en),
      .wr_addr (tag_wr_addr),
      .wr_data (tag_wr_data),
      .rd_en   (tag_rd_en),
      .rd_addr (tag_rd_addr),
      .rd_data (tag_rd_data)
   );

   xfec_back #(
      .HISTORY_SLOTS   (HISTORY_SLOTS),
      .WORDS_PER_FRAME (WORDS_PER_FRAME)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_empty      (cmd_empty),
      .cmd_pop        (cmd_pop),
      .cmd_data       (cmd_rd_data),
      .cmd_slot       (cmd_rd_slot),
      .burst_done     (burst_done),
      .parity_rd_idx  (parity_rd_idx),
      .parity_rd_word (parity_rd_word),
      .tag_rd_en      (tag_rd_en),
      .tag_rd_addr    (tag_rd_addr),
      .tag_rd_data    (tag_rd_data),
      .hist_rd_en     (hist_rd_en),
      .hist_rd_addr   (hist_rd_addr),
      .hist_rd_data   (hist_rd_data),
      .out_count      (out_count),
      .out_push       (out_push),
      .out_data       (out_data)
   );

   xfec_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (out_push),
      .wr_data (out_data),
      .full    (),
      .pop     (rsp_pop),
      .rd_data (out_rd),
      .empty   (rsp_empty),
      .count   (out_count)
   );

endmodule
